/* rtl/core/mhpq_pkg.sv */
// Shared types and codes for the max-heap priority queue.
`timescale 1ns / 1ps
package mhpq_pkg;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic signed [31:0] key;
        logic [31:0]        payload;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_CHK,
        S_INS_CMP,
        S_RM_ROOT,
        S_RM_LAST,
        S_DN_CHK,
        S_DN_L,
        S_DN_R,
        S_DN_CMP,
        S_FIN
    } state_t;

    typedef enum logic [2:0] {
        RA_ROOT,
        RA_PARENT,
        RA_LAST,
        RA_CHILD,
        RA_RIGHT
    } rd_sel_t;

    typedef enum logic [1:0] {
        WS_ENTRY,
        WS_RDATA,
        WS_BEST
    } wr_src_t;

    typedef enum logic [2:0] {
        P_HOLD,
        P_NEW,
        P_HALF,
        P_ROOT,
        P_BEST
    } pos_op_t;

    typedef struct packed {
        logic    load_item;
        logic    count_inc;
        logic    count_dec;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_src_t wr_src;
        pos_op_t pos_op;
        logic    capture_root;
        logic    load_last;
        logic    best_left;
        logic    best_right;
        logic    publish;
    } cmd_t;

    typedef struct packed {
        logic in_remove;
        logic full;
        logic empty;
        logic pos_root;
        logic ins_gt;
        logic child_over;
        logic has_right;
        logic right_gt;
        logic best_gt;
        logic out_busy;
    } stat_t;

endpackage

/* rtl/core/mhpq_ctrl.sv */
// Sequencer for insert (sift up) and remove (sift down) beats.
`timescale 1ns / 1ps
module mhpq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            valid,
    output logic            ready,
    input  mhpq_pkg::stat_t st,
    output mhpq_pkg::cmd_t  cmd
);
    import mhpq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ready      = 1'b0;
        cmd        = '0;
        cmd.rd_sel = RA_ROOT;
        cmd.wr_src = WS_ENTRY;
        cmd.pos_op = P_HOLD;
        unique case (state_reg)
            S_IDLE:
            begin
                ready = 1'b1;
                if (valid)
                begin
                    cmd.load_item = 1'b1;
                    if (!st.in_remove && !st.full)
                    begin
                        cmd.count_inc = 1'b1;
                        cmd.pos_op    = P_NEW;
                        state_next    = S_INS_CHK;
                    end
                    else if (st.in_remove && !st.empty)
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RA_ROOT;
                        state_next = S_RM_ROOT;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_INS_CHK:
            begin
                if (st.pos_root)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_src = WS_ENTRY;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RA_PARENT;
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                cmd.wr_en = 1'b1;
                if (st.ins_gt)
                begin
                    // parent moves down one level
                    cmd.wr_src = WS_RDATA;
                    cmd.pos_op = P_HALF;
                    state_next = S_INS_CHK;
                end
                else
                begin
                    cmd.wr_src = WS_ENTRY;
                    state_next = S_FIN;
                end
            end
            S_RM_ROOT:
            begin
                cmd.capture_root = 1'b1;
                cmd.count_dec    = 1'b1;
                cmd.rd_en        = 1'b1;
                cmd.rd_sel       = RA_LAST;
                state_next       = S_RM_LAST;
            end
            S_RM_LAST:
            begin
                cmd.load_last = 1'b1;
                cmd.pos_op    = P_ROOT;
                state_next    = S_DN_CHK;
            end
            S_DN_CHK:
            begin
                if (st.child_over)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_src = WS_ENTRY;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RA_CHILD;
                    state_next = S_DN_L;
                end
            end
            S_DN_L:
            begin
                cmd.best_left = 1'b1;
                if (st.has_right)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RA_RIGHT;
                    state_next = S_DN_R;
                end
                else
                begin
                    state_next = S_DN_CMP;
                end
            end
            S_DN_R:
            begin
                cmd.best_right = st.right_gt;
                state_next     = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                cmd.wr_en = 1'b1;
                if (st.best_gt)
                begin
                    cmd.wr_src = WS_BEST;
                    cmd.pos_op = P_BEST;
                    state_next = S_DN_CHK;
                end
                else
                begin
                    cmd.wr_src = WS_ENTRY;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!st.out_busy)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/mhpq_dp.sv */
// Heap memory, entry count, position and compare datapath, result register.
`timescale 1ns / 1ps
module mhpq_dp #(
    parameter int CAPACITY = 255
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               kind,
    input  logic signed [31:0] key,
    input  logic [31:0]        payload,
    input  mhpq_pkg::cmd_t     cmd,
    output mhpq_pkg::stat_t    st,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] out_key,
    output logic [31:0]        out_payload,
    output logic [1:0]         status,
    output logic [7:0]         occupancy
);
    import mhpq_pkg::*;

    localparam int AW    = $clog2(CAPACITY + 1);
    localparam int DEPTH = CAPACITY + 1;

    entry_t mem [DEPTH];

    logic [AW-1:0] count_reg;
    logic [AW-1:0] count_next;
    logic [AW-1:0] pos_reg;
    logic [AW-1:0] pos_next;
    logic [AW-1:0] best_idx_reg;
    entry_t        entry_reg;
    entry_t        best_reg;
    entry_t        rdata_reg;
    logic signed [31:0] res_key_reg;
    logic [31:0]   res_payload_reg;
    logic [1:0]    res_status_reg;

    logic               out_valid_reg;
    logic signed [31:0] out_key_reg;
    logic [31:0]        out_payload_reg;
    logic [1:0]         out_status_reg;
    logic [7:0]         out_occ_reg;

    logic [AW:0]   child;
    logic [AW:0]   right;
    logic [AW:0]   raddr;
    entry_t        wdata;
    logic [1:0]    load_status;

    assign child = {pos_reg, 1'b0};
    assign right = {pos_reg, 1'b1};

    always_comb
    begin
        case (cmd.rd_sel)
            RA_ROOT:   raddr = (AW + 1)'(1);
            RA_PARENT: raddr = {1'b0, pos_reg} >> 1;
            RA_LAST:   raddr = {1'b0, count_reg};
            RA_CHILD:  raddr = child;
            RA_RIGHT:  raddr = right;
            default:   raddr = (AW + 1)'(1);
        endcase
    end

    always_comb
    begin
        case (cmd.wr_src)
            WS_ENTRY: wdata = entry_reg;
            WS_RDATA: wdata = rdata_reg;
            WS_BEST:  wdata = best_reg;
            default:  wdata = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[pos_reg] <= wdata;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[raddr[AW-1:0]];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.count_inc)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.count_dec)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_comb
    begin
        case (cmd.pos_op)
            P_NEW:   pos_next = count_reg + 1'b1;
            P_HALF:  pos_next = pos_reg >> 1;
            P_ROOT:  pos_next = AW'(1);
            P_BEST:  pos_next = best_idx_reg;
            default: pos_next = pos_reg;
        endcase
    end

    always_comb
    begin
        if (kind == KIND_REMOVE)
        begin
            load_status = (count_reg == '0) ? ST_EMPTY : ST_DONE;
        end
        else
        begin
            load_status = (count_reg == AW'(CAPACITY)) ? ST_FULL : ST_DONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.publish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        if (cmd.load_item)
        begin
            entry_reg       <= '{key: key, payload: payload};
            res_key_reg     <= '0;
            res_payload_reg <= '0;
            res_status_reg  <= load_status;
        end
        if (cmd.load_last)
        begin
            entry_reg <= rdata_reg;
        end
        if (cmd.capture_root)
        begin
            res_key_reg     <= rdata_reg.key;
            res_payload_reg <= rdata_reg.payload;
        end
        if (cmd.best_left)
        begin
            best_reg     <= rdata_reg;
            best_idx_reg <= child[AW-1:0];
        end
        else if (cmd.best_right)
        begin
            best_reg     <= rdata_reg;
            best_idx_reg <= right[AW-1:0];
        end
        if (cmd.publish)
        begin
            out_key_reg     <= res_key_reg;
            out_payload_reg <= res_payload_reg;
            out_status_reg  <= res_status_reg;
            out_occ_reg     <= 8'(count_reg);
        end
    end

    always_comb
    begin
        st            = '0;
        st.in_remove  = (kind == KIND_REMOVE);
        st.full       = (count_reg == AW'(CAPACITY));
        st.empty      = (count_reg == '0);
        st.pos_root   = (pos_reg == AW'(1));
        st.ins_gt     = (entry_reg.key > rdata_reg.key);
        st.child_over = (child > {1'b0, count_reg});
        st.has_right  = (child < {1'b0, count_reg});
        st.right_gt   = (rdata_reg.key > best_reg.key);
        st.best_gt    = (best_reg.key > entry_reg.key);
        st.out_busy   = out_valid_reg && !out_ready;
    end

    assign out_valid   = out_valid_reg;
    assign out_key     = out_key_reg;
    assign out_payload = out_payload_reg;
    assign status      = out_status_reg;
    assign occupancy   = out_occ_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= AW'(CAPACITY))
        else $error("entry count above capacity");

    a_no_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en |-> pos_reg != '0)
        else $error("heap write to unused slot zero");

    a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> !(out_valid_reg && !out_ready))
        else $error("result register overwritten while held");

    a_full_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_item && kind == KIND_INSERT && st.full) |=> $stable(count_reg))
        else $error("count changed on insert into full heap");

endmodule

/* rtl/core/max_heap_priority_queue.sv */
// Top level of the binary max-heap priority queue.
`timescale 1ns / 1ps
// Binary max-heap of signed 32-bit keys with 32-bit payload handles, held in
// a single-port-read memory of CAPACITY+1 entries (slot zero unused). Each
// input beat inserts (kind 0) or removes the largest entry (kind 1) and gives
// exactly one result beat with the removed entry (zero otherwise), a status
// code (done, remove on empty, insert on full) and the entry count after the
// beat; a rejected beat leaves the heap untouched. Items are handled one at a
// time and the memory allows one registered read per cycle. An insert is
// accepted, then checks its position and, below the root, reads the parent
// and compares, writing the parent down and climbing a level while the key is
// larger, else writing the entry. A remove reads the root, captures it and
// reads the last entry, moves that entry to the root, then per level it sinks
// reads both children (the right one only if present), compares, and writes.
// A rejected beat goes straight to loading its result. The default capacity
// fills eight levels. Loading the result waits while the output register
// still holds an unaccepted result. The next beat is accepted as soon as the
// previous one has been finished, even if its result still sits in the output
// register. No clearing pass runs after reset.
module max_heap_priority_queue #(
    parameter int CAPACITY = 255
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid,
    output logic               ready,
    input  logic               kind,
    input  logic signed [31:0] key,
    input  logic [31:0]        payload,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] out_key,
    output logic [31:0]        out_payload,
    output logic [1:0]         status,
    output logic [7:0]         occupancy
);
    import mhpq_pkg::*;

    cmd_t  cmd;
    stat_t st;

    mhpq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .valid (valid),
        .ready (ready),
        .st    (st),
        .cmd   (cmd)
    );

    mhpq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .kind        (kind),
        .key         (key),
        .payload     (payload),
        .cmd         (cmd),
        .st          (st),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_key     (out_key),
        .out_payload (out_payload),
        .status      (status),
        .occupancy   (occupancy)
    );

endmodule
